>>> rtl/core/i2cseq_pkg.sv
// Shared types, codes, reset values and the command script table of the I2C sequencer.
package i2cseq_pkg;

    // Run modes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_WAIT   = 2'd1;
    localparam logic [1:0] MODE_SETTLE = 2'd2;

    // Command codes
    localparam logic [1:0] OP_ADC_CFG  = 2'd0;
    localparam logic [1:0] OP_ADC_RD   = 2'd1;
    localparam logic [1:0] OP_MEM_WR   = 2'd2;
    localparam logic [1:0] OP_MEM_RD   = 2'd3;

    // Script items
    localparam logic [3:0] IT_START      = 4'd0;
    localparam logic [3:0] IT_STOP       = 4'd1;
    localparam logic [3:0] IT_ACK        = 4'd2;
    localparam logic [3:0] IT_RECV       = 4'd3;
    localparam logic [3:0] IT_NACK       = 4'd4;
    localparam logic [3:0] IT_ADCW       = 4'd5;
    localparam logic [3:0] IT_ADCR       = 4'd6;
    localparam logic [3:0] IT_CTRL       = 4'd7;
    localparam logic [3:0] IT_MEMW       = 4'd8;
    localparam logic [3:0] IT_MEMR       = 4'd9;
    localparam logic [3:0] IT_ADDR       = 4'd10;
    localparam logic [3:0] IT_DATA       = 4'd11;
    localparam logic [3:0] IT_END        = 4'd12;
    localparam logic [3:0] IT_ENDSETTLE  = 4'd13;

    // Resume points after a pin delay
    localparam logic [3:0] RS_ST_B = 4'd0;
    localparam logic [3:0] RS_ST_C = 4'd1;
    localparam logic [3:0] RS_SP_B = 4'd2;
    localparam logic [3:0] RS_SP_C = 4'd3;
    localparam logic [3:0] RS_AK_B = 4'd4;
    localparam logic [3:0] RS_AK_C = 4'd5;
    localparam logic [3:0] RS_TX_B = 4'd6;
    localparam logic [3:0] RS_TX_C = 4'd7;
    localparam logic [3:0] RS_TX_D = 4'd8;
    localparam logic [3:0] RS_RX_B = 4'd9;
    localparam logic [3:0] RS_RX_C = 4'd10;
    localparam logic [3:0] RS_NK_B = 4'd11;
    localparam logic [3:0] RS_NK_C = 4'd12;
    localparam logic [3:0] RS_NK_D = 4'd13;

    // Register indexes
    localparam logic [2:0] REG_DELAY_LENGTH = 3'd0;
    localparam logic [2:0] REG_ADC_ADDR     = 3'd1;
    localparam logic [2:0] REG_ADC_CTRL     = 3'd2;
    localparam logic [2:0] REG_MEM_ADDR     = 3'd3;
    localparam logic [2:0] REG_POST_WAIT    = 3'd4;

    // Register reset values
    localparam logic [7:0]  DELAY_LENGTH_RST = 8'd5;
    localparam logic [6:0]  ADC_ADDR_RST     = 7'd72;
    localparam logic [7:0]  ADC_CTRL_RST     = 8'd3;
    localparam logic [6:0]  MEM_ADDR_RST     = 7'd80;
    localparam logic [15:0] POST_WAIT_RST    = 16'd1120;

    typedef struct packed {
        logic [7:0]  delay_length;
        logic [6:0]  adc_device_address;
        logic [7:0]  adc_control_byte;
        logic [6:0]  eeprom_device_address;
        logic [15:0] post_write_wait;
    } cfg_t;

    typedef struct packed {
        logic       command_valid;
        logic [1:0] op;
        logic [7:0] mem_address;
        logic [7:0] write_data;
        logic       sda_in;
    } tick_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  resume;
        logic [3:0]  script_pos;
        logic [7:0]  delay_count;
        logic [2:0]  bit_count;
        logic [7:0]  shift_byte;
        logic [17:0] latched_command;
        logic [15:0] settle_count;
        logic [7:0]  received_byte;
        logic        nack_flag;
        logic        scl;
        logic        sda;
    } seq_state_t;

    function automatic logic [3:0] script_item(input logic [1:0] op, input logic [3:0] pos);
        logic [3:0] item;
        begin
            item = IT_END;
            unique case (op)
                OP_ADC_CFG: begin
                    unique case (pos)
                        4'd0: item = IT_START;
                        4'd1: item = IT_ADCW;
                        4'd2: item = IT_ACK;
                        4'd3: item = IT_CTRL;
                        4'd4: item = IT_ACK;
                        4'd5: item = IT_STOP;
                        4'd6: item = IT_ENDSETTLE;
                        default: item = IT_END;
                    endcase
                end
                OP_ADC_RD: begin
                    unique case (pos)
                        4'd0: item = IT_START;
                        4'd1: item = IT_ADCR;
                        4'd2: item = IT_ACK;
                        4'd3: item = IT_RECV;
                        4'd4: item = IT_NACK;
                        4'd5: item = IT_STOP;
                        default: item = IT_END;
                    endcase
                end
                OP_MEM_WR: begin
                    unique case (pos)
                        4'd0: item = IT_START;
                        4'd1: item = IT_MEMW;
                        4'd2: item = IT_ACK;
                        4'd3: item = IT_ADDR;
                        4'd4: item = IT_ACK;
                        4'd5: item = IT_DATA;
                        4'd6: item = IT_ACK;
                        4'd7: item = IT_STOP;
                        4'd8: item = IT_ENDSETTLE;
                        default: item = IT_END;
                    endcase
                end
                OP_MEM_RD: begin
                    unique case (pos)
                        4'd0:  item = IT_START;
                        4'd1:  item = IT_MEMW;
                        4'd2:  item = IT_ACK;
                        4'd3:  item = IT_ADDR;
                        4'd4:  item = IT_ACK;
                        4'd5:  item = IT_STOP;
                        4'd6:  item = IT_START;
                        4'd7:  item = IT_MEMR;
                        4'd8:  item = IT_ACK;
                        4'd9:  item = IT_RECV;
                        4'd10: item = IT_NACK;
                        4'd11: item = IT_STOP;
                        default: item = IT_END;
                    endcase
                end
                default: item = IT_END;
            endcase
            return item;
        end
    endfunction

endpackage

>>> rtl/core/i2cseq_step.sv
// Next-state logic of the sequencer for one tick: finish the current pin segment, enter the next item.
module i2cseq_step (
    input  i2cseq_pkg::seq_state_t cur,
    input  i2cseq_pkg::cfg_t       cfg,
    input  i2cseq_pkg::tick_t      tick,
    output i2cseq_pkg::seq_state_t nxt,
    output logic                   done
);

    logic       tail;
    logic       ret;
    logic       enter;
    logic       dly;
    logic [3:0] dly_target;
    logic [3:0] item;

    always_comb begin
        nxt        = cur;
        done       = 1'b0;
        tail       = 1'b0;
        ret        = 1'b0;
        enter      = 1'b0;
        dly        = 1'b0;
        dly_target = i2cseq_pkg::RS_ST_B;
        item       = i2cseq_pkg::IT_END;

        unique case (cur.mode)
            i2cseq_pkg::MODE_IDLE: begin
                if (tick.command_valid) begin
                    nxt.latched_command = {tick.write_data, tick.mem_address, tick.op};
                    nxt.nack_flag       = 1'b0;
                    nxt.script_pos      = 4'd0;
                    enter               = 1'b1;
                end
            end
            i2cseq_pkg::MODE_WAIT: begin
                if (cur.delay_count != 8'd0) begin
                    nxt.delay_count = cur.delay_count - 8'd1;
                end else begin
                    tail = 1'b1;
                end
            end
            i2cseq_pkg::MODE_SETTLE: begin
                nxt.settle_count = cur.settle_count - 16'd1;
                if (nxt.settle_count == 16'd0) begin
                    nxt.mode = i2cseq_pkg::MODE_IDLE;
                    done     = 1'b1;
                end
            end
            default: begin
                nxt.mode = i2cseq_pkg::MODE_IDLE;
            end
        endcase

        // finish the segment that follows the expired delay
        if (tail) begin
            unique case (cur.resume)
                i2cseq_pkg::RS_ST_B: begin
                    nxt.sda    = 1'b0;
                    dly        = 1'b1;
                    dly_target = i2cseq_pkg::RS_ST_C;
                end
                i2cseq_pkg::RS_ST_C: begin
                    nxt.scl = 1'b0;
                    ret     = 1'b1;
                end
                i2cseq_pkg::RS_SP_B: begin
                    nxt.sda    = 1'b1;
                    dly        = 1'b1;
                    dly_target = i2cseq_pkg::RS_SP_C;
                end
                i2cseq_pkg::RS_SP_C: ret = 1'b1;
                i2cseq_pkg::RS_AK_B: begin
                    nxt.nack_flag = cur.nack_flag | tick.sda_in;
                    nxt.scl       = 1'b0;
                    dly           = 1'b1;
                    dly_target    = i2cseq_pkg::RS_AK_C;
                end
                i2cseq_pkg::RS_AK_C: ret = 1'b1;
                i2cseq_pkg::RS_TX_B: begin
                    nxt.sda    = cur.shift_byte[7];
                    dly        = 1'b1;
                    dly_target = i2cseq_pkg::RS_TX_C;
                end
                i2cseq_pkg::RS_TX_C: begin
                    nxt.scl        = 1'b1;
                    nxt.shift_byte = {cur.shift_byte[6:0], 1'b0};
                    nxt.bit_count  = cur.bit_count + 3'd1;
                    dly            = 1'b1;
                    dly_target     = i2cseq_pkg::RS_TX_D;
                end
                i2cseq_pkg::RS_TX_D: begin
                    nxt.scl = 1'b0;
                    if (cur.bit_count != 3'd0) begin
                        dly        = 1'b1;
                        dly_target = i2cseq_pkg::RS_TX_B;
                    end else begin
                        ret = 1'b1;
                    end
                end
                i2cseq_pkg::RS_RX_B: begin
                    nxt.shift_byte = {cur.shift_byte[6:0], tick.sda_in};
                    nxt.bit_count  = cur.bit_count + 3'd1;
                    nxt.scl        = 1'b0;
                    dly            = 1'b1;
                    dly_target     = i2cseq_pkg::RS_RX_C;
                end
                i2cseq_pkg::RS_RX_C: begin
                    if (cur.bit_count != 3'd0) begin
                        nxt.scl    = 1'b1;
                        dly        = 1'b1;
                        dly_target = i2cseq_pkg::RS_RX_B;
                    end else begin
                        nxt.received_byte = cur.shift_byte;
                        ret               = 1'b1;
                    end
                end
                i2cseq_pkg::RS_NK_B: begin
                    nxt.scl    = 1'b1;
                    dly        = 1'b1;
                    dly_target = i2cseq_pkg::RS_NK_C;
                end
                i2cseq_pkg::RS_NK_C: begin
                    nxt.scl    = 1'b0;
                    nxt.sda    = 1'b1;
                    dly        = 1'b1;
                    dly_target = i2cseq_pkg::RS_NK_D;
                end
                default: ret = 1'b1;
            endcase
        end

        if (ret) begin
            nxt.script_pos = cur.script_pos + 4'd1;
            enter          = 1'b1;
        end

        // enter the next script item and run its head segment
        if (enter) begin
            item = i2cseq_pkg::script_item(nxt.latched_command[1:0], nxt.script_pos);
            unique case (item)
                i2cseq_pkg::IT_START: begin
                    nxt.sda    = 1'b1;
                    nxt.scl    = 1'b1;
                    dly        = 1'b1;
                    dly_target = i2cseq_pkg::RS_ST_B;
                end
                i2cseq_pkg::IT_STOP: begin
                    nxt.sda    = 1'b0;
                    nxt.scl    = 1'b1;
                    dly        = 1'b1;
                    dly_target = i2cseq_pkg::RS_SP_B;
                end
                i2cseq_pkg::IT_ACK: begin
                    nxt.sda    = 1'b1;
                    nxt.scl    = 1'b1;
                    dly        = 1'b1;
                    dly_target = i2cseq_pkg::RS_AK_B;
                end
                i2cseq_pkg::IT_NACK: begin
                    nxt.scl    = 1'b0;
                    nxt.sda    = 1'b1;
                    dly        = 1'b1;
                    dly_target = i2cseq_pkg::RS_NK_B;
                end
                i2cseq_pkg::IT_RECV: begin
                    nxt.shift_byte = 8'd0;
                    nxt.bit_count  = 3'd0;
                    nxt.scl        = 1'b1;
                    dly            = 1'b1;
                    dly_target     = i2cseq_pkg::RS_RX_B;
                end
                i2cseq_pkg::IT_ADCW, i2cseq_pkg::IT_ADCR, i2cseq_pkg::IT_CTRL,
                i2cseq_pkg::IT_MEMW, i2cseq_pkg::IT_MEMR, i2cseq_pkg::IT_ADDR,
                i2cseq_pkg::IT_DATA: begin
                    unique case (item)
                        i2cseq_pkg::IT_ADCW: nxt.shift_byte = {cfg.adc_device_address, 1'b0};
                        i2cseq_pkg::IT_ADCR: nxt.shift_byte = {cfg.adc_device_address, 1'b1};
                        i2cseq_pkg::IT_CTRL: nxt.shift_byte = cfg.adc_control_byte;
                        i2cseq_pkg::IT_MEMW: nxt.shift_byte = {cfg.eeprom_device_address, 1'b0};
                        i2cseq_pkg::IT_MEMR: nxt.shift_byte = {cfg.eeprom_device_address, 1'b1};
                        i2cseq_pkg::IT_ADDR: nxt.shift_byte = nxt.latched_command[9:2];
                        default:             nxt.shift_byte = nxt.latched_command[17:10];
                    endcase
                    nxt.bit_count = 3'd0;
                    nxt.scl       = 1'b0;
                    dly           = 1'b1;
                    dly_target    = i2cseq_pkg::RS_TX_B;
                end
                i2cseq_pkg::IT_ENDSETTLE: begin
                    if (cfg.post_write_wait != 16'd0) begin
                        nxt.settle_count = cfg.post_write_wait;
                        nxt.mode         = i2cseq_pkg::MODE_SETTLE;
                    end else begin
                        nxt.mode = i2cseq_pkg::MODE_IDLE;
                        done     = 1'b1;
                    end
                end
                default: begin
                    nxt.mode = i2cseq_pkg::MODE_IDLE;
                    done     = 1'b1;
                end
            endcase
        end

        if (dly) begin
            nxt.mode        = i2cseq_pkg::MODE_WAIT;
            nxt.delay_count = cfg.delay_length;
            nxt.resume      = dly_target;
        end
    end

endmodule

>>> rtl/core/i2c_master_transaction_sequencer_core.sv
// Top level of the tick-driven I2C master: stream channels, APB registers and sequencer state.
//
// Each request on the s_ channel is one timing tick of the bus waveform and yields exactly one
// result on the m_ channel holding the pin levels, busy and done flags, last read byte and
// acknowledge status after that tick. One tick is taken every clock cycle; a result is offered
// on m_ through an input register and a result register, and back-pressure on m_ stalls s_ only
// once both are full. Registers sit on the APB port at byte addresses 0x00 delay_length,
// 0x04 adc_device_address, 0x08 adc_control_byte, 0x0C eeprom_device_address,
// 0x10 post_write_wait; write them only while no command runs.
module i2c_master_transaction_sequencer_core (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: mem_address[7:0], write_data[15:8], sda_in[16], zero pad[23:17]
    input  logic [23:0] s_tdata,
    // s_tuser: command_valid[0], op[2:1]
    input  logic [2:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata: scl_out[0], sda_out[1], busy_res[2], done_res[3], read_data[11:4],
    //          nack_seen[12], zero pad[15:13]
    output logic [15:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    i2cseq_pkg::cfg_t       cfg_reg;
    i2cseq_pkg::tick_t      tick_reg;
    logic                   tick_valid_reg;
    logic                   tick_valid_next;
    i2cseq_pkg::seq_state_t state_reg;
    i2cseq_pkg::seq_state_t state_next;
    logic                   done_next;
    logic [15:0]            result_reg;
    logic [15:0]            result_next;
    logic                   result_valid_reg;
    logic                   fire;
    logic                   cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.delay_length          <= i2cseq_pkg::DELAY_LENGTH_RST;
            cfg_reg.adc_device_address    <= i2cseq_pkg::ADC_ADDR_RST;
            cfg_reg.adc_control_byte      <= i2cseq_pkg::ADC_CTRL_RST;
            cfg_reg.eeprom_device_address <= i2cseq_pkg::MEM_ADDR_RST;
            cfg_reg.post_write_wait       <= i2cseq_pkg::POST_WAIT_RST;
        end else if (cfg_write) begin
            case (paddr[4:2])
                i2cseq_pkg::REG_DELAY_LENGTH: cfg_reg.delay_length          <= pwdata[7:0];
                i2cseq_pkg::REG_ADC_ADDR:     cfg_reg.adc_device_address    <= pwdata[6:0];
                i2cseq_pkg::REG_ADC_CTRL:     cfg_reg.adc_control_byte      <= pwdata[7:0];
                i2cseq_pkg::REG_MEM_ADDR:     cfg_reg.eeprom_device_address <= pwdata[6:0];
                i2cseq_pkg::REG_POST_WAIT:    cfg_reg.post_write_wait       <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            i2cseq_pkg::REG_DELAY_LENGTH: prdata = {24'd0, cfg_reg.delay_length};
            i2cseq_pkg::REG_ADC_ADDR:     prdata = {25'd0, cfg_reg.adc_device_address};
            i2cseq_pkg::REG_ADC_CTRL:     prdata = {24'd0, cfg_reg.adc_control_byte};
            i2cseq_pkg::REG_MEM_ADDR:     prdata = {25'd0, cfg_reg.eeprom_device_address};
            i2cseq_pkg::REG_POST_WAIT:    prdata = {16'd0, cfg_reg.post_write_wait};
            default:                      prdata = 32'd0;
        endcase
    end

    // advance a tick when the result register is free or being drained
    assign fire     = tick_valid_reg & (~result_valid_reg | m_tready);
    assign s_tready = ~tick_valid_reg | fire;

    always_comb begin
        if (s_tvalid & s_tready) begin
            tick_valid_next = 1'b1;
        end else if (fire) begin
            tick_valid_next = 1'b0;
        end else begin
            tick_valid_next = tick_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_valid_reg <= 1'b0;
        end else begin
            tick_valid_reg <= tick_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid & s_tready) begin
            tick_reg.command_valid <= s_tuser[0];
            tick_reg.op            <= s_tuser[2:1];
            tick_reg.mem_address   <= s_tdata[7:0];
            tick_reg.write_data    <= s_tdata[15:8];
            tick_reg.sda_in        <= s_tdata[16];
        end
    end

    i2cseq_step u_step (
        .cur  (state_reg),
        .cfg  (cfg_reg),
        .tick (tick_reg),
        .nxt  (state_next),
        .done (done_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode            <= i2cseq_pkg::MODE_IDLE;
            state_reg.resume          <= i2cseq_pkg::RS_ST_B;
            state_reg.script_pos      <= 4'd0;
            state_reg.delay_count     <= 8'd0;
            state_reg.bit_count       <= 3'd0;
            state_reg.shift_byte      <= 8'd0;
            state_reg.latched_command <= 18'd0;
            state_reg.settle_count    <= 16'd0;
            state_reg.received_byte   <= 8'd0;
            state_reg.nack_flag       <= 1'b0;
            state_reg.scl             <= 1'b1;
            state_reg.sda             <= 1'b1;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    assign result_next = {3'd0, state_next.nack_flag, state_next.received_byte, done_next,
                          (state_next.mode != i2cseq_pkg::MODE_IDLE), state_next.sda,
                          state_next.scl};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            result_valid_reg <= 1'b0;
        end else if (fire) begin
            result_valid_reg <= 1'b1;
        end else if (m_tready) begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            result_reg <= result_next;
        end
    end

    assign m_tdata  = result_reg;
    assign m_tvalid = result_valid_reg;

`ifndef SYNTHESIS
    // a completion pulse always leaves the sequencer idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && done_next) |=> (state_reg.mode == i2cseq_pkg::MODE_IDLE))
        else $error("done pulse without return to idle");

    // settling follows a stop, so both lines are released
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.mode == i2cseq_pkg::MODE_SETTLE) |-> (state_reg.scl && state_reg.sda))
        else $error("bus lines not released while settling");

    // an idle tick without a command keeps the sequencer idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && (state_reg.mode == i2cseq_pkg::MODE_IDLE) && !tick_reg.command_valid)
        |=> (state_reg.mode == i2cseq_pkg::MODE_IDLE))
        else $error("sequencer left idle without a command");
`endif

endmodule

>>> test/i2cseq_checker.sv
// Checker for the I2C sequencer: predicts every bus status result and compares it.
module i2cseq_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [23:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          error_count,
    output int          pending_count,
    output logic        seq_idle
);
    import i2cseq_pkg::*;

    typedef enum logic [3:0] {
        ACT_CLK_LO, ACT_CLK_HI, ACT_DAT_LO, ACT_DAT_HI, ACT_DAT_BIT, ACT_PAUSE,
        ACT_SHIFT_OUT, ACT_ACK_SAMPLE, ACT_SHIFT_IN, ACT_TX_LOOP, ACT_RX_LOOP,
        ACT_KEEP, ACT_RETURN
    } pin_act_t;

    typedef struct packed {
        logic       nack_seen;
        logic [7:0] read_data;
        logic       done_res;
        logic       busy_res;
        logic       sda_out;
        logic       scl_out;
    } bus_status_t;

    localparam logic [5:0] PC_START = 6'd0;
    localparam logic [5:0] PC_STOP  = 6'd7;
    localparam logic [5:0] PC_ACK   = 6'd13;
    localparam logic [5:0] PC_SEND  = 6'd20;
    localparam logic [5:0] PC_RECV  = 6'd30;
    localparam logic [5:0] PC_NACK  = 6'd38;

    cfg_t        cfg;
    logic [1:0]  run_mode;
    logic [5:0]  pc;
    logic [3:0]  script_idx;
    logic [7:0]  pause_left;
    logic [2:0]  bits_done;
    logic [7:0]  shreg;
    logic [17:0] held_cmd;
    logic [15:0] settle_left;
    logic [7:0]  last_rx;
    logic        nack_flag;
    logic        scl_lvl;
    logic        sda_lvl;
    logic        done_now;
    int          result_index;
    bus_status_t status_q[$];

    assign seq_idle = (run_mode == MODE_IDLE);

    function automatic pin_act_t pin_action(input logic [5:0] at);
        pin_act_t act;
        case (at)
            6'd5, 6'd17, 6'd20, 6'd28, 6'd33, 6'd38, 6'd43: act = ACT_CLK_LO;
            6'd1, 6'd8, 6'd14, 6'd24, 6'd30, 6'd41:         act = ACT_CLK_HI;
            6'd3, 6'd7:                                     act = ACT_DAT_LO;
            6'd0, 6'd10, 6'd13, 6'd39, 6'd44:               act = ACT_DAT_HI;
            6'd22:                                          act = ACT_DAT_BIT;
            6'd2, 6'd4, 6'd9, 6'd11, 6'd15, 6'd18, 6'd21,
            6'd23, 6'd26, 6'd31, 6'd34, 6'd40, 6'd42, 6'd45: act = ACT_PAUSE;
            6'd25:                                          act = ACT_SHIFT_OUT;
            6'd16:                                          act = ACT_ACK_SAMPLE;
            6'd32:                                          act = ACT_SHIFT_IN;
            6'd27:                                          act = ACT_TX_LOOP;
            6'd35:                                          act = ACT_RX_LOOP;
            6'd36:                                          act = ACT_KEEP;
            default:                                        act = ACT_RETURN;
        endcase
        return act;
    endfunction

    function automatic logic [3:0] script_step(input logic [1:0] op, input logic [3:0] at);
        logic [51:0] steps;
        steps = {13{IT_END}};
        case (op)
            OP_ADC_CFG: steps = {IT_START, IT_ADCW, IT_ACK, IT_CTRL, IT_ACK, IT_STOP,
                                 IT_ENDSETTLE, {6{IT_END}}};
            OP_ADC_RD:  steps = {IT_START, IT_ADCR, IT_ACK, IT_RECV, IT_NACK, IT_STOP,
                                 {7{IT_END}}};
            OP_MEM_WR:  steps = {IT_START, IT_MEMW, IT_ACK, IT_ADDR, IT_ACK, IT_DATA,
                                 IT_ACK, IT_STOP, IT_ENDSETTLE, {4{IT_END}}};
            OP_MEM_RD:  steps = {IT_START, IT_MEMW, IT_ACK, IT_ADDR, IT_ACK, IT_STOP,
                                 IT_START, IT_MEMR, IT_ACK, IT_RECV, IT_NACK, IT_STOP,
                                 IT_END};
            default: ;
        endcase
        if (at > 4'd12)
            return IT_END;
        return steps[(12 - int'(at)) * 4 +: 4];
    endfunction

    task automatic finish_command(input bit with_settle);
        if (with_settle && cfg.post_write_wait != 16'd0) begin
            settle_left = cfg.post_write_wait;
            run_mode = MODE_SETTLE;
        end else begin
            run_mode = MODE_IDLE;
            done_now = 1'b1;
        end
    endtask

    task automatic load_tx(input logic [7:0] value);
        shreg = value;
        bits_done = 3'd0;
        pc = PC_SEND;
    endtask

    task automatic enter_step(output bit started);
        logic [3:0] item;
        item = script_step(held_cmd[1:0], script_idx);
        started = 1'b1;
        case (item)
            IT_START: pc = PC_START;
            IT_STOP:  pc = PC_STOP;
            IT_ACK:   pc = PC_ACK;
            IT_NACK:  pc = PC_NACK;
            IT_RECV: begin
                shreg = 8'd0;
                bits_done = 3'd0;
                pc = PC_RECV;
            end
            IT_ADCW: load_tx({cfg.adc_device_address, 1'b0});
            IT_ADCR: load_tx({cfg.adc_device_address, 1'b1});
            IT_CTRL: load_tx(cfg.adc_control_byte);
            IT_MEMW: load_tx({cfg.eeprom_device_address, 1'b0});
            IT_MEMR: load_tx({cfg.eeprom_device_address, 1'b1});
            IT_ADDR: load_tx(held_cmd[9:2]);
            IT_DATA: load_tx(held_cmd[17:10]);
            IT_ENDSETTLE: begin
                finish_command(1'b1);
                started = 1'b0;
            end
            default: begin
                finish_command(1'b0);
                started = 1'b0;
            end
        endcase
    endtask

    task automatic run_pins(input logic sda_smp);
        pin_act_t act;
        bit running;
        running = 1'b1;
        while (running) begin
            act = pin_action(pc);
            pc = pc + 6'd1;
            case (act)
                ACT_CLK_LO:     scl_lvl = 1'b0;
                ACT_CLK_HI:     scl_lvl = 1'b1;
                ACT_DAT_LO:     sda_lvl = 1'b0;
                ACT_DAT_HI:     sda_lvl = 1'b1;
                ACT_DAT_BIT:    sda_lvl = shreg[7];
                ACT_PAUSE: begin
                    pause_left = cfg.delay_length;
                    run_mode = MODE_WAIT;
                    running = 1'b0;
                end
                ACT_SHIFT_OUT: begin
                    shreg = {shreg[6:0], 1'b0};
                    bits_done = bits_done + 3'd1;
                end
                ACT_ACK_SAMPLE: nack_flag = nack_flag | sda_smp;
                ACT_SHIFT_IN: begin
                    shreg = {shreg[6:0], sda_smp};
                    bits_done = bits_done + 3'd1;
                end
                ACT_TX_LOOP:    if (bits_done != 3'd0) pc = PC_SEND;
                ACT_RX_LOOP:    if (bits_done != 3'd0) pc = PC_RECV;
                ACT_KEEP:       last_rx = shreg;
                default: begin
                    script_idx = script_idx + 4'd1;
                    enter_step(running);
                end
            endcase
        end
    endtask

    task automatic advance_tick(input tick_t tk, output bus_status_t status);
        bit started;
        done_now = 1'b0;
        case (run_mode)
            MODE_IDLE: begin
                if (tk.command_valid) begin
                    held_cmd = {tk.write_data, tk.mem_address, tk.op};
                    nack_flag = 1'b0;
                    script_idx = 4'd0;
                    enter_step(started);
                    if (started)
                        run_pins(tk.sda_in);
                end
            end
            MODE_WAIT: begin
                if (pause_left != 8'd0)
                    pause_left = pause_left - 8'd1;
                else
                    run_pins(tk.sda_in);
            end
            MODE_SETTLE: begin
                settle_left = settle_left - 16'd1;
                if (settle_left == 16'd0) begin
                    run_mode = MODE_IDLE;
                    done_now = 1'b1;
                end
            end
            default: ;
        endcase
        status.scl_out   = scl_lvl;
        status.sda_out   = sda_lvl;
        status.busy_res  = (run_mode != MODE_IDLE);
        status.done_res  = done_now;
        status.read_data = last_rx;
        status.nack_seen = nack_flag;
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
        case (idx)
            REG_DELAY_LENGTH: cfg.delay_length = value[7:0];
            REG_ADC_ADDR:     cfg.adc_device_address = value[6:0];
            REG_ADC_CTRL:     cfg.adc_control_byte = value[7:0];
            REG_MEM_ADDR:     cfg.eeprom_device_address = value[6:0];
            REG_POST_WAIT:    cfg.post_write_wait = value[15:0];
            default: ;
        endcase
    endtask

    task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
        $display("mismatch at result %0d: %s got %0h expected %0h",
                 result_index, what, got, want);
        error_count++;
    endtask

    task automatic check_status(input logic [15:0] data);
        bus_status_t got;
        bus_status_t want;
        got = data[12:0];
        if (status_q.size() == 0) begin
            report("result with nothing expected", data[7:0], 8'd0);
        end else begin
            want = status_q.pop_front();
            if (got.scl_out !== want.scl_out)
                report("scl_out", 8'(got.scl_out), 8'(want.scl_out));
            if (got.sda_out !== want.sda_out)
                report("sda_out", 8'(got.sda_out), 8'(want.sda_out));
            if (got.busy_res !== want.busy_res)
                report("busy_res", 8'(got.busy_res), 8'(want.busy_res));
            if (got.done_res !== want.done_res)
                report("done_res", 8'(got.done_res), 8'(want.done_res));
            if (got.read_data !== want.read_data)
                report("read_data", got.read_data, want.read_data);
            if (got.nack_seen !== want.nack_seen)
                report("nack_seen", 8'(got.nack_seen), 8'(want.nack_seen));
        end
        result_index++;
    endtask

    task automatic reset_model();
        cfg.delay_length = DELAY_LENGTH_RST;
        cfg.adc_device_address = ADC_ADDR_RST;
        cfg.adc_control_byte = ADC_CTRL_RST;
        cfg.eeprom_device_address = MEM_ADDR_RST;
        cfg.post_write_wait = POST_WAIT_RST;
        run_mode = MODE_IDLE;
        pc = 6'd0;
        script_idx = 4'd0;
        pause_left = 8'd0;
        bits_done = 3'd0;
        shreg = 8'd0;
        held_cmd = 18'd0;
        settle_left = 16'd0;
        last_rx = 8'd0;
        nack_flag = 1'b0;
        scl_lvl = 1'b1;
        sda_lvl = 1'b1;
        done_now = 1'b0;
        status_q.delete();
        error_count = 0;
        result_index = 0;
    endtask

    always @(posedge aclk) begin : watch
        tick_t tk;
        bus_status_t want;
        if (!aresetn) begin
            reset_model();
        end else begin
            if (psel && penable && pwrite && pready)
                write_register(paddr[4:2], pwdata);
            if (m_tvalid && m_tready)
                check_status(m_tdata);
            if (s_tvalid && s_tready) begin
                tk.command_valid = s_tuser[0];
                tk.op = s_tuser[2:1];
                tk.mem_address = s_tdata[7:0];
                tk.write_data = s_tdata[15:8];
                tk.sda_in = s_tdata[16];
                advance_tick(tk, want);
                status_q.push_back(want);
            end
        end
        pending_count = status_q.size();
    end

endmodule

>>> test/tb_top.sv
// Top of the I2C sequencer testbench: clock, reset, tick and register stimulus, verdict.
module tb_top;
    import i2cseq_pkg::*;

    localparam int         CYCLE_LIMIT = 200_000;
    localparam int         LONG_HOLD   = 300;
    localparam logic [4:0] SPARE_ADDR  = 5'h1C;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic [23:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    bit   gaps_on      = 1'b0;
    bit   hold_off_req = 1'b0;
    int   cycle_count;
    int   error_count;
    int   pending_count;
    logic seq_idle;

    i2c_master_transaction_sequencer_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    i2cseq_checker i_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .m_tdata       (m_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .error_count   (error_count),
        .pending_count (pending_count),
        .seq_idle      (seq_idle)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    initial begin : cycle_guard
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin : receiver
        bit held;
        int n;
        held = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                m_tready <= 1'b1;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 6);
                m_tready <= 1'b0;
                repeat (n) @(negedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    function automatic tick_t filler_tick(input int ones_in_8, input bit may_command);
        tick_t t;
        t.command_valid = may_command && ($urandom_range(0, 3) == 0);
        t.op = 2'($urandom);
        t.mem_address = 8'($urandom);
        t.write_data = 8'($urandom);
        t.sda_in = ($urandom_range(0, 7) < ones_in_8);
        return t;
    endfunction

    task automatic send_tick(input tick_t t);
        int n;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, t.sda_in, t.write_data, t.mem_address};
        s_tuser <= {t.op, t.command_valid};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic run_command(input logic [1:0] op, input logic [7:0] addr,
                               input logic [7:0] data, input int ones_in_8);
        tick_t t;
        t = filler_tick(ones_in_8, 1'b0);
        t.command_valid = 1'b1;
        t.op = op;
        t.mem_address = addr;
        t.write_data = data;
        send_tick(t);
        while (!seq_idle) send_tick(filler_tick(ones_in_8, 1'b1));
    endtask

    task automatic random_commands(input int count);
        int ones;
        repeat (count) begin
            repeat ($urandom_range(0, 3)) send_tick(filler_tick(4, 1'b0));
            ones = 1 + 3 * $urandom_range(0, 2);
            run_command(2'($urandom), 8'($urandom), 8'($urandom), ones);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [4:0] addr, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_regs(input logic [7:0] dly, input logic [6:0] adc_addr,
                            input logic [7:0] ctrl, input logic [6:0] mem_addr,
                            input logic [15:0] settle_ticks);
        write_reg({REG_DELAY_LENGTH, 2'b00}, 32'(dly));
        write_reg({REG_ADC_ADDR, 2'b00}, 32'(adc_addr));
        write_reg({REG_ADC_CTRL, 2'b00}, 32'(ctrl));
        write_reg({REG_MEM_ADDR, 2'b00}, 32'(mem_addr));
        write_reg({REG_POST_WAIT, 2'b00}, 32'(settle_ticks));
    endtask

    initial begin : stimulus
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        gaps_on = 1'b1;
        send_tick(filler_tick(0, 1'b0));
        run_command(OP_ADC_RD, 8'hFF, 8'hFF, 8);
        drain();

        set_regs(8'd0, 7'd0, 8'd0, 7'd127, 16'd0);
        write_reg(SPARE_ADDR, 32'hFFFF_FFFF);
        run_command(OP_MEM_WR, 8'h5A, 8'hA5, 8);
        run_command(OP_ADC_CFG, 8'hA5, 8'h5A, 0);
        run_command(OP_MEM_RD, 8'hFF, 8'h00, 7);
        drain();

        set_regs(8'd0, 7'd127, 8'd255, 7'd0, 16'd1);
        hold_off_req = 1'b1;
        random_commands(2);
        drain();

        gaps_on = 1'b0;
        set_regs(8'd1, 7'($urandom), 8'($urandom), 7'($urandom), 16'($urandom_range(1, 3)));
        random_commands(1);
        drain();

        if (error_count == 0 && pending_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
